// ----- design/bcd_pkg.sv -----
// ----------------------------------------------------------------------------
// bcd_pkg: shared types and constants for the binomial coefficient core
// Field widths and the control bundle between the sequencer and the row bank.
// ----------------------------------------------------------------------------
package bcd_pkg;

  localparam int IDX_W = 6;   // width of n and k
  localparam int VAL_W = 60;  // width of one table cell and of the result

  // control from the sequencer to the row bank
  typedef struct packed {
    logic clear;      // mark every cell of both rows as one
    logic wr_en;      // write a cell of the newer row
    logic newer_sel;  // 0: row a is newer, 1: row b is newer
  } bank_ctl_t;

endpackage

// ----- design/bcd_ram.sv -----
// ----------------------------------------------------------------------------
// bcd_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module bcd_ram #(
  parameter int WIDTH = 60,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ----- design/bcd_rows.sv -----
// ----------------------------------------------------------------------------
// bcd_rows: two alternating Pascal rows
// Writes go to the newer row, reads come from the older row. Per-cell valid
// bits let a single clear reset both rows to all ones.
// ----------------------------------------------------------------------------
module bcd_rows #(
  parameter int DEPTH = 64
) (
  input  logic                      clk,
  input  logic                      rst,
  input  bcd_pkg::bank_ctl_t        ctl,
  input  logic [$clog2(DEPTH)-1:0]  wr_addr,
  input  logic [bcd_pkg::VAL_W-1:0] wr_data,
  input  logic [$clog2(DEPTH)-1:0]  rd_addr,
  output logic [bcd_pkg::VAL_W-1:0] rd_data
);

  import bcd_pkg::*;

  logic [DEPTH-1:0] valid_a;
  logic [DEPTH-1:0] valid_b;
  logic             rd_from_b;
  logic             rd_valid;
  logic [VAL_W-1:0] q_a;
  logic [VAL_W-1:0] q_b;
  logic [VAL_W-1:0] q_old;

  bcd_ram #(.WIDTH(VAL_W), .DEPTH(DEPTH)) u_row_a (
    .clk     (clk),
    .wr_en   (ctl.wr_en && !ctl.newer_sel),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (q_a)
  );

  bcd_ram #(.WIDTH(VAL_W), .DEPTH(DEPTH)) u_row_b (
    .clk     (clk),
    .wr_en   (ctl.wr_en && ctl.newer_sel),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (q_b)
  );

  // the older row is the one not being written
  always_ff @(posedge clk) begin
    if (rst) begin
      valid_a   <= '0;
      valid_b   <= '0;
      rd_from_b <= 1'b0;
      rd_valid  <= 1'b0;
    end else begin
      rd_from_b <= !ctl.newer_sel;
      rd_valid  <= ctl.newer_sel ? valid_a[rd_addr] : valid_b[rd_addr];
      if (ctl.clear) begin
        valid_a <= '0;
        valid_b <= '0;
      end else if (ctl.wr_en) begin
        if (ctl.newer_sel) begin
          valid_b[wr_addr] <= 1'b1;
        end else begin
          valid_a[wr_addr] <= 1'b1;
        end
      end
    end
  end

  assign q_old   = rd_from_b ? q_b : q_a;
  // an unwritten cell reads as one
  assign rd_data = rd_valid ? q_old : VAL_W'(1);

endmodule

// ----- design/binomial_coefficient_dp_core.sv -----
// ----------------------------------------------------------------------------
// binomial_coefficient_dp_core: n choose k by Pascal-triangle tabulation
// Sequencer and shared 60-bit adder over two alternating row memories.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel: drive total_items (n) and chosen_items (k) and raise
//   start; the transaction is taken at a rising edge where start is high and
//   busy is low. Response channel: done pulses for exactly one cycle with the
//   exact 60-bit value on coefficient; there is no back-pressure, so the
//   receiver must capture the transaction in that cycle.
//   Special cases answer in the cycle after acceptance without going busy:
//   k = 0 or k = n gives 1, k > n gives 0, n > MAX_N gives 0.
//   Otherwise the core tabulates rows 2..n, one cell per cycle through the
//   single adder while in S_CELL. Row i updates cells lo..hi, with
//   lo = max(1, i-n+k) and hi = min(k, i-1), after S_ROW and S_FIRST prime
//   the row-memory read pipeline; the final fetch of cell k goes through
//   S_FETCH and S_LAST. busy stays high for the whole tabulation.
//   Reset (rst, synchronous) returns the sequencer to idle and drops any
//   transaction in flight; rows need no clearing since each tabulated item
//   starts by marking both rows as all ones through per-cell valid bits.
// ----------------------------------------------------------------------------
module binomial_coefficient_dp_core #(
  parameter int MAX_N = 63
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  output logic                      busy,
  input  logic [bcd_pkg::IDX_W-1:0] total_items,
  input  logic [bcd_pkg::IDX_W-1:0] chosen_items,
  output logic                      done,
  output logic [bcd_pkg::VAL_W-1:0] coefficient
);

  import bcd_pkg::*;

  localparam int DEPTH = MAX_N + 1;
  localparam int AW    = $clog2(DEPTH);

  typedef enum logic [2:0] {
    S_IDLE,
    S_ROW,
    S_FIRST,
    S_CELL,
    S_FETCH,
    S_LAST
  } state_t;

  state_t           state;
  logic [AW-1:0]    n;
  logic [AW-1:0]    k;
  logic [AW-1:0]    i;
  logic [AW-1:0]    j;
  logic [AW-1:0]    hi;
  logic [VAL_W-1:0] prev;
  logic             newer_sel;

  logic             accept;
  logic             out_of_range;
  logic             trivial_one;
  logic             tab_go;
  logic [AW:0]      sum_ik;
  logic [AW-1:0]    lo;
  logic [AW-1:0]    hi_next;
  logic [AW-1:0]    i_less1;
  logic [AW-1:0]    rd_addr;
  logic [VAL_W-1:0] rd_data;
  logic [VAL_W-1:0] cell_sum;
  bank_ctl_t        ctl;

  assign busy   = (state != S_IDLE);
  assign accept = start && !busy;

  // classify the request as it arrives
  assign out_of_range = (total_items > IDX_W'(MAX_N));
  assign trivial_one  = (chosen_items == '0) || (chosen_items == total_items);
  assign tab_go       = !out_of_range && !trivial_one && (chosen_items < total_items);

  // band of cells that row i must update
  assign sum_ik  = {1'b0, i} + {1'b0, k};
  assign lo      = (sum_ik >= ({1'b0, n} + (AW+1)'(1))) ? AW'(sum_ik - {1'b0, n}) : AW'(1);
  assign i_less1 = i - AW'(1);
  assign hi_next = (k < i_less1) ? k : i_less1;

  // the shared adder: cell above plus cell above-left
  assign cell_sum = rd_data + prev;

  always_comb begin
    ctl           = '0;
    ctl.newer_sel = newer_sel;
    rd_addr       = j;
    case (state)
      S_IDLE:  begin
        ctl.clear = accept && tab_go;
      end
      S_ROW:   begin
        rd_addr = lo - AW'(1);
      end
      S_FIRST: begin
        rd_addr = j;
      end
      S_CELL:  begin
        rd_addr    = j + AW'(1);
        ctl.wr_en  = 1'b1;
      end
      S_FETCH: begin
        rd_addr = k;
      end
      default: begin
        rd_addr = j;
      end
    endcase
  end

  bcd_rows #(.DEPTH(DEPTH)) u_rows (
    .clk     (clk),
    .rst     (rst),
    .ctl     (ctl),
    .wr_addr (j),
    .wr_data (cell_sum),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      done      <= 1'b0;
      newer_sel <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (accept) begin
            if (tab_go) begin
              // latch the request and start at row two with row a newer
              n         <= AW'(total_items);
              k         <= AW'(chosen_items);
              i         <= AW'(2);
              newer_sel <= 1'b0;
              state     <= S_ROW;
            end else begin
              // answer the special cases at once
              done        <= 1'b1;
              coefficient <= (!out_of_range && trivial_one) ? VAL_W'(1) : '0;
            end
          end
        end
        S_ROW: begin
          // read of the above-left cell is in flight
          j     <= lo;
          hi    <= hi_next;
          state <= S_FIRST;
        end
        S_FIRST: begin
          prev  <= rd_data;
          state <= S_CELL;
        end
        S_CELL: begin
          prev <= rd_data;
          if (j == hi) begin
            newer_sel <= !newer_sel;
            if (i == n) begin
              state <= S_FETCH;
            end else begin
              i     <= i + AW'(1);
              state <= S_ROW;
            end
          end else begin
            j <= j + AW'(1);
          end
        end
        S_FETCH: begin
          state <= S_LAST;
        end
        S_LAST: begin
          done        <= 1'b1;
          coefficient <= rd_data;
          state       <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ----- design/bcd_checker.sv -----
// ----------------------------------------------------------------------------
// bcd_checker: port-level checks for the binomial coefficient core
// Watches request and response transactions on the top-level ports.
// ----------------------------------------------------------------------------
module bcd_checker #(
  parameter int MAX_N = 63
) (
  input logic                      clk,
  input logic                      rst,
  input logic                      start,
  input logic                      busy,
  input logic [bcd_pkg::IDX_W-1:0] total_items,
  input logic [bcd_pkg::IDX_W-1:0] chosen_items,
  input logic                      done,
  input logic [bcd_pkg::VAL_W-1:0] coefficient
);

  import bcd_pkg::*;

  logic accept;
  logic in_range;

  assign accept   = start && !busy;
  assign in_range = (total_items <= IDX_W'(MAX_N));

  // a response always leaves the core ready for the next request
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("response while busy");

  a_trivial_one: assert property (@(posedge clk) disable iff (rst)
    (accept && in_range && (chosen_items == '0 || chosen_items == total_items))
      |=> (done && coefficient == VAL_W'(1)))
    else $error("k of zero or n must give one");

  a_k_above_n: assert property (@(posedge clk) disable iff (rst)
    (accept && chosen_items > total_items) |=> (done && coefficient == '0))
    else $error("k above n must give zero");

  a_tabulate_busy: assert property (@(posedge clk) disable iff (rst)
    (accept && in_range && chosen_items != '0 && chosen_items < total_items)
      |=> (busy && !done))
    else $error("tabulating request must hold busy");

endmodule

bind binomial_coefficient_dp_core bcd_checker #(.MAX_N(MAX_N)) u_bcd_checker (
  .clk          (clk),
  .rst          (rst),
  .start        (start),
  .busy         (busy),
  .total_items  (total_items),
  .chosen_items (chosen_items),
  .done         (done),
  .coefficient  (coefficient)
);

// ----- tb/sv/binomial_coefficient_dp_core_tb.sv -----
// ----------------------------------------------------------------------------
// binomial_coefficient_dp_core_tb: self-checking bench for the n-choose-k core
// Walks a table of corner requests, then a long mix of random requests
// weighted toward small n, with random idle bursts before some requests. Each
// done pulse is compared against the table value for typed corners, else a
// Pascal-row predictor that mirrors the core's two-row tabulation at 60 bits.
// ----------------------------------------------------------------------------
module binomial_coefficient_dp_core_tb;
  import bcd_pkg::*;

  localparam int RANDOM_REQUESTS = 580;
  localparam int CALM_TAIL       = 60;    // last requests go back to back
  localparam int DRAIN_POINT     = 290;   // sender waits for an empty queue here
  localparam int SETTLE_CYCLES   = 1200;  // above the worst tabulation latency
  localparam int N_DIRECTED      = 21;

  logic             clk;
  logic             rst;
  logic             start;
  logic             busy;
  logic [IDX_W-1:0] total_items;
  logic [IDX_W-1:0] chosen_items;
  logic             done;
  logic [VAL_W-1:0] coefficient;

  // one corner request; value is used only when typed is set
  typedef struct packed {
    logic [IDX_W-1:0] n;
    logic [IDX_W-1:0] k;
    logic             typed;
    logic [VAL_W-1:0] value;
  } corner_request_t;

  // one outstanding coefficient, kept with its request for messages
  typedef struct packed {
    logic [IDX_W-1:0] n;
    logic [IDX_W-1:0] k;
    logic [VAL_W-1:0] value;
  } pending_coef_t;

  corner_request_t corner_table [N_DIRECTED];
  pending_coef_t   coef_expected [$];
  pending_coef_t   oldest_coef;

  int mismatch_count;
  int requests_sent;
  int tabulated_requests;
  int direct_requests;
  int results_checked;

  binomial_coefficient_dp_core DUT (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .total_items  (total_items),
    .chosen_items (chosen_items),
    .done         (done),
    .coefficient  (coefficient)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Bound the run: worst case is every request at full size with a maximum
  // idle burst in front; allow several times that.
  initial begin
    #40000000;
    $display("binomial_coefficient_dp_core_tb: FAIL");
    $finish;
  end

  task automatic report_mismatch(input string msg);
    $display("MISMATCH @%0t: %s", $realtime, msg);
    mismatch_count++;
  endtask

  // Build C(n,k) the way the core does: two rows of ones, rows 2..n updated
  // only over the window that can still reach cell k, then swap roles.
  function automatic logic [VAL_W-1:0] pascal_choose(input int n, input int k);
    logic [VAL_W-1:0] cells [2][64];
    int newer;
    int i;
    int j;
    int lo;
    int hi;
    if (k == 0 || k == n) return VAL_W'(1);
    if (k > n) return VAL_W'(0);
    for (i = 0; i < 64; i++) begin
      cells[0][i] = VAL_W'(1);
      cells[1][i] = VAL_W'(1);
    end
    newer = 0;
    for (i = 2; i <= n; i++) begin
      lo = (i + k >= n + 1) ? (i + k - n) : 1;
      hi = (k < i - 1) ? k : (i - 1);
      for (j = lo; j <= hi; j++) begin
        cells[newer][j] = cells[1 - newer][j] + cells[1 - newer][j - 1];
      end
      newer = 1 - newer;
    end
    return cells[1 - newer][k];
  endfunction

  // Drop start for a random burst and scramble the fields meanwhile, so the
  // core must ignore them.
  task automatic idle_burst();
    int gap;
    gap = $urandom_range(16, 1);
    start        <= 1'b0;
    total_items  <= IDX_W'($urandom);
    chosen_items <= IDX_W'($urandom);
    repeat (gap) @(posedge clk);
  endtask

  // Hold one request until the core takes it, then queue its coefficient.
  task automatic issue_request(input logic [IDX_W-1:0] n, input logic [IDX_W-1:0] k,
                               input logic typed, input logic [VAL_W-1:0] typed_value);
    pending_coef_t entry;
    start        <= 1'b1;
    total_items  <= n;
    chosen_items <= k;
    do @(posedge clk); while (busy);
    entry.n     = n;
    entry.k     = k;
    entry.value = typed ? typed_value : pascal_choose(int'(n), int'(k));
    coef_expected.push_back(entry);
    requests_sent++;
    if (k == 0 || k == n || k > n) direct_requests++;
    else tabulated_requests++;
  endtask

  // Pick a random request: short tabulations most often, some long ones, plenty
  // of direct answers, and a share with both fields fully random.
  task automatic pick_request(input int idx, output logic [IDX_W-1:0] n,
                              output logic [IDX_W-1:0] k);
    int mix;
    mix = $urandom_range(99, 0);
    if (idx % 97 == 13) begin
      // widest row of the triangle, slowest case
      n = IDX_W'(63);
      k = ($urandom_range(1, 0) != 0) ? IDX_W'(31) : IDX_W'(32);
    end else if (mix < 45) begin
      n = IDX_W'($urandom_range(12, 2));
      k = IDX_W'($urandom_range(n - 1, 1));
    end else if (mix < 60) begin
      n = IDX_W'($urandom_range(40, 13));
      k = IDX_W'($urandom_range(n - 1, 1));
    end else if (mix < 65) begin
      n = IDX_W'($urandom_range(63, 41));
      k = IDX_W'($urandom_range(n - 1, 1));
    end else if (mix < 75) begin
      n = IDX_W'($urandom_range(63, 0));
      k = ($urandom_range(1, 0) != 0) ? n : IDX_W'(0);
    end else if (mix < 85) begin
      n = IDX_W'($urandom_range(62, 0));
      k = IDX_W'($urandom_range(63, n + 1));
    end else begin
      n = IDX_W'($urandom);
      k = IDX_W'($urandom);
    end
  endtask

  // Check every done pulse against the oldest outstanding coefficient.
  always @(posedge clk) begin
    if (!rst && done) begin
      if (coef_expected.size() == 0) begin
        report_mismatch($sformatf("result %0d with no request outstanding", coefficient));
      end else begin
        oldest_coef = coef_expected.pop_front();
        if (coefficient !== oldest_coef.value) begin
          report_mismatch($sformatf("C(%0d,%0d): got %0d, want %0d", oldest_coef.n,
                                    oldest_coef.k, coefficient, oldest_coef.value));
        end
      end
      results_checked++;
    end
  end

  initial begin
    logic [IDX_W-1:0] req_n;
    logic [IDX_W-1:0] req_k;

    mismatch_count     = 0;
    requests_sent      = 0;
    tabulated_requests = 0;
    direct_requests    = 0;
    results_checked    = 0;

    // Corners: empty and full fields, k = 0 and k = n, k above n, the edges
    // and the peak of the last row; untyped rows go through the predictor.
    corner_table = '{
      '{6'd0,  6'd0,  1'b1, 60'd1},
      '{6'd1,  6'd0,  1'b1, 60'd1},
      '{6'd1,  6'd1,  1'b1, 60'd1},
      '{6'd63, 6'd0,  1'b1, 60'd1},
      '{6'd63, 6'd63, 1'b1, 60'd1},
      '{6'd0,  6'd63, 1'b1, 60'd0},
      '{6'd0,  6'd1,  1'b1, 60'd0},
      '{6'd62, 6'd63, 1'b1, 60'd0},
      '{6'd5,  6'd63, 1'b1, 60'd0},
      '{6'd2,  6'd1,  1'b1, 60'd2},
      '{6'd63, 6'd1,  1'b1, 60'd63},
      '{6'd63, 6'd62, 1'b1, 60'd63},
      '{6'd63, 6'd31, 1'b1, 60'd916312070471295267},
      '{6'd63, 6'd32, 1'b1, 60'd916312070471295267},
      '{6'd3,  6'd2,  1'b0, 60'd0},
      '{6'd10, 6'd5,  1'b0, 60'd0},
      '{6'd20, 6'd7,  1'b0, 60'd0},
      '{6'd62, 6'd31, 1'b0, 60'd0},
      '{6'd40, 6'd20, 1'b0, 60'd0},
      '{6'd42, 6'd21, 1'b0, 60'd0},
      '{6'd21, 6'd10, 1'b0, 60'd0}
    };

    // Hold every input at a known value through reset.
    rst          = 1'b1;
    start        = 1'b0;
    total_items  = '0;
    chosen_items = '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Walk the corner table with occasional gaps in front of a request.
    for (int idx = 0; idx < N_DIRECTED; idx++) begin
      if ($urandom_range(3, 0) == 0) idle_burst();
      issue_request(corner_table[idx].n, corner_table[idx].k,
                    corner_table[idx].typed, corner_table[idx].value);
    end

    // Random phase; idle bursts stop for the last stretch so back-to-back
    // transactions meet a busy core.
    for (int idx = 0; idx < RANDOM_REQUESTS; idx++) begin
      if (idx == DRAIN_POINT) begin
        // stall the sender until every outstanding result is back
        start <= 1'b0;
        while (coef_expected.size() != 0) @(posedge clk);
      end else if (idx < RANDOM_REQUESTS - CALM_TAIL && $urandom_range(3, 0) == 0) begin
        idle_burst();
      end
      pick_request(idx, req_n, req_k);
      issue_request(req_n, req_k, 1'b0, '0);
    end

    // Release start, wait out the queue, then give stray pulses time to show.
    start <= 1'b0;
    while (coef_expected.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (coef_expected.size() != 0) begin
      report_mismatch($sformatf("%0d results never arrived", coef_expected.size()));
    end

    $display("Run covered %0d requests: %0d tabulated, %0d answered directly.",
             requests_sent, tabulated_requests, direct_requests);
    $display("Checked %0d results, %0d mismatches.", results_checked, mismatch_count);
    if (mismatch_count == 0) begin
      $display("binomial_coefficient_dp_core_tb: PASS");
    end else begin
      $display("binomial_coefficient_dp_core_tb: FAIL");
    end
    $finish;
  end

endmodule

// ----- files.f -----
design/bcd_pkg.sv
design/bcd_ram.sv
design/bcd_rows.sv
design/binomial_coefficient_dp_core.sv
design/bcd_checker.sv
tb/sv/binomial_coefficient_dp_core_tb.sv
